>>> hdl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; imported by sem_ctrl, sem_dp and sobel_edge_magnitude.
`default_nettype none
package sem_pkg;

  localparam int PIX_W   = 8;
  localparam int DIM_CFG = 13;
  localparam int COORD_W = 12;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // grey = sum / 3 as (sum * 683) >> 11, exact for sum <= 765
  localparam logic [9:0]  DIV3_MUL = 10'd683;
  // |g| / 9 as (|g| * 7282) >> 16, exact for |g| <= 1020
  localparam logic [12:0] DIV9_MUL = 13'd7282;

  // result slots of one pixel
  localparam logic [1:0] SEL_CENTER = 2'd0;
  localparam logic [1:0] SEL_RIGHT  = 2'd1;
  localparam logic [1:0] SEL_BOTTOM = 2'd2;

  typedef struct packed {
    logic       load_px;
    logic       upd_win;
    logic       calc_grad;
    logic       calc_div;
    logic       calc_sq;
    logic       sqrt_init;
    logic       sqrt_step;
    logic [2:0] sqrt_bit;
    logic       emit;
    logic [1:0] emit_sel;
  } sem_cmd_t;

  typedef struct packed {
    logic has_center;
    logic has_right;
    logic has_bottom;
    logic out_free;
  } sem_sts_t;

endpackage
`default_nettype wire

>>> hdl/sem_ctrl.sv
// Sequencer for one pixel: fetch, window update, gradient, root, emission.
// Depends on sem_pkg.
`default_nettype none
module sem_ctrl import sem_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  sem_sts_t      sts,
  output sem_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WIN, S_GRAD, S_DIV, S_SQ, S_SQRT, S_EM0, S_EM1, S_EM2
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] bit_r, bit_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.sqrt_bit = bit_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_px = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD:   state_nxt = S_WIN;
      S_WIN: begin
        cmd.upd_win = 1'b1;
        state_nxt   = S_GRAD;
      end
      S_GRAD: begin
        cmd.calc_grad = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.calc_div = 1'b1;
        state_nxt    = S_SQ;
      end
      S_SQ: begin
        cmd.calc_sq   = 1'b1;
        cmd.sqrt_init = 1'b1;
        bit_nxt       = 3'd7;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        bit_nxt       = bit_r - 3'd1;
        if (bit_r == 3'd0) state_nxt = S_EM0;
      end
      S_EM0: begin
        if (!sts.has_center) begin
          state_nxt = S_EM1;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_CENTER;
          state_nxt    = S_EM1;
        end
      end
      S_EM1: begin
        if (!sts.has_right) begin
          state_nxt = S_EM2;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_RIGHT;
          state_nxt    = S_EM2;
        end
      end
      S_EM2: begin
        if (!sts.has_bottom) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_BOTTOM;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("emit into occupied output register");
  a_load_win: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_px |=> ##1 cmd.upd_win) else $error("window update missed after load");
  a_sqrt_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sqrt_step && cmd.sqrt_bit == 3'd0) |=> !cmd.sqrt_step)
    else $error("root iteration overran");

endmodule
`default_nettype wire

>>> hdl/sem_dp.sv
// Datapath: grey conversion, row stores, 3x3 window, Sobel, root, output register.
// Depends on sem_pkg.
`default_nettype none
module sem_dp import sem_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [PIX_W-1:0]   in_red,
  input  wire logic [PIX_W-1:0]   in_green,
  input  wire logic [PIX_W-1:0]   in_blue,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [DIM_CFG-1:0] cfg_data,
  input  sem_cmd_t                cmd,
  output sem_sts_t                sts,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [PIX_W-1:0]        out_edge_value,
  output logic [COORD_W-1:0]      out_row,
  output logic [COORD_W-1:0]      out_col,
  output logic                    out_last_of_run
);

  localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [DIM_CFG-1:0] width_r, height_r;
  logic [CW-1:0]      cnt_c_r, pc_r;
  logic [RW-1:0]      cnt_r_r, pr_r;
  logic [PIX_W-1:0]   grey_r, rd_old_r, rd_new_r;
  logic [PIX_W-1:0]   older_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   win_r [3][3];
  logic signed [11:0] gx_r, gy_r;
  logic [6:0]         qx_r, qy_r;
  logic [15:0]        sq_r;
  logic [7:0]         root_r;
  logic               out_valid_r, last_r;
  logic [PIX_W-1:0]   edge_r;
  logic [COORD_W-1:0] orow_r, ocol_r;

  function automatic logic [31:0] eff_dim(input logic [DIM_CFG-1:0] v, input int maxv);
    logic [31:0] res;
    res = 32'(v);
    if (v == '0) res = 32'd1;
    else if (res > 32'(maxv)) res = 32'(maxv);
    return res;
  endfunction

  logic [31:0] w_eff, h_eff;
  assign w_eff = eff_dim(width_r, MAX_WIDTH);
  assign h_eff = eff_dim(height_r, MAX_HEIGHT);

  // position of the arriving pixel, restarted if out of frame
  logic          wrap;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  assign wrap  = (32'(cnt_r_r) >= h_eff) || (32'(cnt_c_r) >= w_eff);
  assign c_cur = wrap ? '0 : cnt_c_r;
  assign r_cur = wrap ? '0 : cnt_r_r;

  logic [9:0]  rgb_sum;
  logic [19:0] grey_prod;
  assign rgb_sum   = 10'(in_red) + 10'(in_green) + 10'(in_blue);
  assign grey_prod = rgb_sum * DIV3_MUL;

  logic [CW-1:0] c_nxt;
  logic [RW-1:0] r_nxt;
  always_comb begin
    c_nxt = c_cur + 1'b1;
    r_nxt = r_cur;
    if (32'(c_cur) + 32'd1 >= w_eff) begin
      c_nxt = '0;
      r_nxt = (32'(r_cur) + 32'd1 >= h_eff) ? '0 : r_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_CFG'(640);
      height_r <= DIM_CFG'(480);
      cnt_c_r  <= '0;
      cnt_r_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) width_r  <= cfg_data;
      else                        height_r <= cfg_data;
      cnt_c_r <= '0;
      cnt_r_r <= '0;
    end else if (cmd.load_px) begin
      cnt_c_r <= c_nxt;
      cnt_r_r <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      pc_r     <= c_cur;
      pr_r     <= r_cur;
      grey_r   <= grey_prod[18:11];
      rd_old_r <= older_mem[c_cur];
      rd_new_r <= newer_mem[c_cur];
    end
    if (cmd.upd_win) begin
      older_mem[pc_r] <= rd_new_r;
      newer_mem[pc_r] <= grey_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win_r[i][j] <= '0;
    end else if (cmd.upd_win) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= rd_old_r;
      win_r[1][2] <= rd_new_r;
      win_r[2][2] <= grey_r;
    end
  end

  // gradients, divide by nine, squares, then one root bit per cycle
  logic [10:0] ax, ay;
  logic [22:0] px, py;
  logic [7:0]  trial;
  logic [15:0] trial_sq;
  assign ax = gx_r[11] ? 11'(-gx_r) : gx_r[10:0];
  assign ay = gy_r[11] ? 11'(-gy_r) : gy_r[10:0];
  assign px = ax[9:0] * DIV9_MUL;
  assign py = ay[9:0] * DIV9_MUL;
  assign trial    = root_r | (8'd1 << cmd.sqrt_bit);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (cmd.calc_grad) begin
      gx_r <= 12'(win_r[0][2]) - 12'(win_r[0][0]) + 12'({win_r[1][2], 1'b0})
            - 12'({win_r[1][0], 1'b0}) + 12'(win_r[2][2]) - 12'(win_r[2][0]);
      gy_r <= 12'(win_r[2][0]) - 12'(win_r[0][0]) + 12'({win_r[2][1], 1'b0})
            - 12'({win_r[0][1], 1'b0}) + 12'(win_r[2][2]) - 12'(win_r[0][2]);
    end
    if (cmd.calc_div) begin
      qx_r <= px[22:16];
      qy_r <= py[22:16];
    end
    if (cmd.calc_sq) sq_r <= 16'(qx_r * qx_r) + 16'(qy_r * qy_r);
    if (cmd.sqrt_init) root_r <= '0;
    else if (cmd.sqrt_step && trial_sq <= sq_r) root_r <= trial;
  end

  // result flags for the latched position
  logic interior;
  assign sts.has_center = (pr_r != '0) && (pc_r != '0);
  assign sts.has_right  = (pr_r != '0) && (32'(pc_r) == w_eff - 32'd1);
  assign sts.has_bottom = (32'(pr_r) == h_eff - 32'd1);
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign interior       = (32'(pr_r) >= 32'd2) && (32'(pc_r) >= 32'd2);

  logic [31:0] pr_w, pc_w, pr_m1, pc_m1;
  assign pr_w  = 32'(pr_r);
  assign pc_w  = 32'(pc_r);
  assign pr_m1 = pr_w - 32'd1;
  assign pc_m1 = pc_w - 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        SEL_CENTER: begin
          edge_r <= interior ? root_r : win_r[1][1];
          orow_r <= pr_m1[COORD_W-1:0];
          ocol_r <= pc_m1[COORD_W-1:0];
          last_r <= !sts.has_right && !sts.has_bottom;
        end
        SEL_RIGHT: begin
          edge_r <= win_r[1][2];
          orow_r <= pr_m1[COORD_W-1:0];
          ocol_r <= pc_w[COORD_W-1:0];
          last_r <= !sts.has_bottom;
        end
        default: begin
          edge_r <= grey_r;
          orow_r <= pr_w[COORD_W-1:0];
          ocol_r <= pc_w[COORD_W-1:0];
          last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_edge_value  = edge_r;
  assign out_row         = orow_r;
  assign out_col         = ocol_r;
  assign out_last_of_run = last_r;

endmodule
`default_nettype wire

>>> hdl/sobel_edge_magnitude.sv
// Sobel edge magnitude: a pixel is accepted only while the sequencer is idle, so each
// pixel passes fetch, window update, gradient, divide, square, root and emission
// before the next is accepted, and an output stall holds the emission states.
// The 8-step root iteration and the registered row-store read are part of the pixel period.
// Synchronous active-low reset restarts the frame, sets 640x480 and clears the
// window; row-store contents stay undefined until written.
`default_nettype none
module sobel_edge_magnitude import sem_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [PIX_W-1:0]   in_red,
  input  wire logic [PIX_W-1:0]   in_green,
  input  wire logic [PIX_W-1:0]   in_blue,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [PIX_W-1:0]        out_edge_value,
  output logic [COORD_W-1:0]      out_row,
  output logic [COORD_W-1:0]      out_col,
  output logic                    out_last_of_run,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [DIM_CFG-1:0] cfg_data
);

  sem_cmd_t cmd;
  sem_sts_t sts;

  // sequence each pixel: fetch, window, gradient, root, up to three beats
  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold line stores, window and the output register that decouples the sink
  sem_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_edge_value  (out_edge_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire
